### src/i2cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C temperature sensor command model - shared definitions
// Types, command and mode codes, and the CRC-8 helper used by the block.
// ----------------------------------------------------------------------------
package i2cts_pkg;

   // Command codes carried in the func field.
   localparam logic [2:0] FUNC_RESET    = 3'd0;
   localparam logic [2:0] FUNC_CONVERT  = 3'd1;
   localparam logic [2:0] FUNC_RD_SER   = 3'd2;
   localparam logic [2:0] FUNC_RD_ADC   = 3'd3;
   localparam logic [2:0] FUNC_TICK     = 3'd4;

   // Device modes.
   localparam logic [2:0] MODE_UNKNOWN    = 3'd0;
   localparam logic [2:0] MODE_RESET      = 3'd1;
   localparam logic [2:0] MODE_IDLE       = 3'd2;
   localparam logic [2:0] MODE_CONVERTING = 3'd3;
   localparam logic [2:0] MODE_CONVERTED  = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_PROTO_ERR = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_SERIAL     = 2'd0;
   localparam logic [1:0] REG_RESET_WAIT = 2'd1;
   localparam logic [1:0] REG_CONV_WAIT  = 2'd2;

   localparam logic [7:0] CRC_POLY      = 8'h31;
   localparam logic [7:0] MS_SATURATE   = 8'hff;
   localparam logic [2:0] SERIAL_LENGTH = 3'd4;
   localparam logic [2:0] ADC_LENGTH    = 3'd3;

   localparam int unsigned ADDR_WIDTH = 4;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] sample_code;
      logic [2:0]  read_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [2:0]  data_bytes;
   } rsp_type;

   typedef struct packed {
      logic [23:0] serial_number;
      logic [7:0]  reset_wait_ms;
      logic [7:0]  convert_wait_ms;
   } cfg_type;

   // One byte of CRC-8, MSB first, no final inversion.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data);
      logic [7:0] crc;
      crc = crc_in ^ data;
      for (int b = 0; b < 8; b++) begin
         if (crc[7]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

### src/i2c_temp_sensor_command_model_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C temperature sensor command model - top level
// Command-level model of a CRC-8 protected temperature sensor.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the request channel (req_valid, req_stall,
// req_data) carries one command or one millisecond tick, and every request
// produces exactly one transfer on the response channel (rsp_valid,
// rsp_stall, rsp_data) holding the status, up to four read bytes and their
// count. The serial number and the two wait times are set through the
// APB-style register port; they should only be written while no request is
// in flight.
// Flow. A request is captured in the input register at the edge on which
// it is accepted; the command engine decodes and executes it once the
// output register is free or is being emptied, and its response is loaded
// into the output register at the edge on which it executes, raising
// rsp_valid. One request is accepted in every cycle while the receiver
// does not raise rsp_stall.
// Stalls. When the receiver raises rsp_stall, the held response stays put
// and the input register holds its request; req_stall rises only once the
// input register is full and cannot move on, so nothing is lost.
// Reset. A synchronous, active-high reset empties both registers, returns
// the device to the unknown mode with a zero timer and code, and restores
// the register defaults (serial 0, reset wait 2 ms, convert wait 5 ms).
// ----------------------------------------------------------------------------
module i2c_temp_sensor_command_model_core
   import i2cts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_type               req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_type               rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_vld_ff;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_vld_ff;
   logic    fire;
   logic    req_take;

   // The engine executes the held request when the output register is free
   // or is being emptied in this cycle.
   assign fire      = item_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   assign req_stall = item_vld_ff & ~fire;
   assign req_take  = req_valid & ~req_stall;

   i2cts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   i2cts_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Input register: valid bit under reset, payload loaded on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_take) begin
         item_vld_ff <= 1'b1;
      end else if (fire) begin
         item_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   // Output register: holds a response until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### src/i2cts_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C temperature sensor command model - configuration registers
// APB-style register file holding the serial number and the two wait times.
// ----------------------------------------------------------------------------
module i2cts_csr
   import i2cts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready,
   output      cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_SERIAL:     cfg_in.serial_number   = pwdata[23:0];
            REG_RESET_WAIT: cfg_in.reset_wait_ms   = pwdata[7:0];
            REG_CONV_WAIT:  cfg_in.convert_wait_ms = pwdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SERIAL:     prdata = {8'd0, cfg_ff.serial_number};
         REG_RESET_WAIT: prdata = {24'd0, cfg_ff.reset_wait_ms};
         REG_CONV_WAIT:  prdata = {24'd0, cfg_ff.convert_wait_ms};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.serial_number   <= 24'd0;
         cfg_ff.reset_wait_ms   <= 8'd2;
         cfg_ff.convert_wait_ms <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### src/i2cts_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C temperature sensor command model - command engine
// Holds the device mode, the millisecond counter and the latched ADC code,
// and works out the result of one command in a single pass.
// ----------------------------------------------------------------------------
module i2cts_engine
   import i2cts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output      rsp_type result
);

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  ms_ff, ms_in;
   logic [15:0] adc_ff, adc_in;
   logic [7:0]  ms_inc;
   logic [7:0]  ser_crc;
   logic [7:0]  adc_crc;

   assign ms_inc = (ms_ff == MS_SATURATE) ? ms_ff : ms_ff + 8'd1;

   assign ser_crc = crc8_byte(crc8_byte(crc8_byte(8'd0, cfg.serial_number[23:16]),
                                        cfg.serial_number[15:8]),
                              cfg.serial_number[7:0]);
   assign adc_crc = crc8_byte(crc8_byte(8'd0, adc_ff[15:8]), adc_ff[7:0]);

   always_comb begin
      mode_in = mode_ff;
      ms_in   = ms_ff;
      adc_in  = adc_ff;
      result  = '{status: ST_OK, read_data: 32'd0, data_bytes: 3'd0};
      unique case (item.func)
         FUNC_RESET: begin
            mode_in = MODE_RESET;
            ms_in   = 8'd0;
         end
         FUNC_CONVERT: begin
            if (mode_ff == MODE_RESET || mode_ff == MODE_IDLE ||
                mode_ff == MODE_CONVERTING) begin
               mode_in = MODE_CONVERTING;
               ms_in   = 8'd0;
            end else begin
               result.status = ST_PROTO_ERR;
            end
         end
         FUNC_RD_SER: begin
            if (mode_ff != MODE_RESET || item.read_length != SERIAL_LENGTH) begin
               result.status = ST_PROTO_ERR;
            end else begin
               result.read_data  = {cfg.serial_number, ser_crc};
               result.data_bytes = SERIAL_LENGTH;
            end
         end
         FUNC_RD_ADC: begin
            if (item.read_length != ADC_LENGTH) begin
               result.status = ST_PROTO_ERR;
            end else if (mode_ff == MODE_CONVERTING) begin
               result.data_bytes = ADC_LENGTH;
            end else if (mode_ff == MODE_CONVERTED) begin
               result.read_data  = {8'd0, adc_ff, adc_crc};
               result.data_bytes = ADC_LENGTH;
               mode_in = MODE_IDLE;
               ms_in   = 8'd0;
            end else begin
               result.status = ST_NOT_READY;
            end
         end
         FUNC_TICK: begin
            ms_in = ms_inc;
            if (mode_ff == MODE_RESET && ms_inc > cfg.reset_wait_ms) begin
               mode_in = MODE_IDLE;
               ms_in   = 8'd0;
            end else if (mode_ff == MODE_CONVERTING &&
                         ms_inc > cfg.convert_wait_ms) begin
               adc_in  = item.sample_code;
               mode_in = MODE_CONVERTED;
               ms_in   = 8'd0;
            end
         end
         default: begin
            result.status = ST_PROTO_ERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNKNOWN;
         ms_ff   <= 8'd0;
         adc_ff  <= 16'd0;
      end else if (fire) begin
         mode_ff <= mode_in;
         ms_ff   <= ms_in;
         adc_ff  <= adc_in;
      end
   end

endmodule
`default_nettype wire

### verif/tb_i2c_temp_sensor_command_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C temperature sensor command model
// Drives commands and millisecond ticks through the request channel, predicts
// every response with a behavioural mirror of the sensor, and checks each
// response transfer field by field under random idling, long back-pressure
// and several register settings, including the extreme wait times.
// ----------------------------------------------------------------------------
module tb_i2c_temp_sensor_command_model_core;
   import i2cts_pkg::*;

   // Depth of the path from an accepted request to its response being presented.
   localparam int LATENCY        = 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;
   localparam int LONG_HOLD      = 120;
   // Highest value the func field can carry; codes above the tick are undefined.
   localparam int FUNC_MAX       = 7;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   i2c_temp_sensor_command_model_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Mirror of the sensor: register copies and the device state.
   logic [23:0] cfg_serial     = 24'd0;
   logic [7:0]  cfg_reset_wait = 8'd2;
   logic [7:0]  cfg_conv_wait  = 8'd5;
   logic [2:0]  dev_mode       = MODE_UNKNOWN;
   logic [7:0]  ms_count       = 8'd0;
   logic [15:0] adc_latch      = 16'd0;

   // Responses still owed by the block, oldest first.
   rsp_type awaited_replies[$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   bit hold_ask      = 1'b0;
   int hold_left     = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int replies_seen  = 0;
   int cfg_writes    = 0;
   int input_stalls  = 0;
   int quiet_cycles  = 0;

   // The clock runs with a 12 ns period from time zero.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioural mirror
   // ------------------------------------------------------------------------

   // CRC-8 over one octet, polynomial 0x31, most significant bit first.
   function automatic logic [7:0] crc8_update(logic [7:0] acc, logic [7:0] octet);
      logic [7:0] c;
      c = acc ^ octet;
      repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Every mode entry restarts the millisecond count, re-entry included.
   function automatic void enter_mode(logic [2:0] m);
      dev_mode = m;
      ms_count = 8'd0;
   endfunction

   // Works out the response to one accepted command and advances the mirror.
   function automatic rsp_type sensor_reply(req_type cmd);
      rsp_type    r;
      logic [7:0] crc;
      r = '0;
      r.status = ST_OK;
      case (cmd.func)
         FUNC_RESET: begin
            enter_mode(MODE_RESET);
         end
         FUNC_CONVERT: begin
            if (dev_mode == MODE_RESET || dev_mode == MODE_IDLE ||
                dev_mode == MODE_CONVERTING) begin
               enter_mode(MODE_CONVERTING);
            end else begin
               r.status = ST_PROTO_ERR;
            end
         end
         FUNC_RD_SER: begin
            if (dev_mode != MODE_RESET || cmd.read_length != SERIAL_LENGTH) begin
               r.status = ST_PROTO_ERR;
            end else begin
               crc = crc8_update(8'h00, cfg_serial[23:16]);
               crc = crc8_update(crc, cfg_serial[15:8]);
               crc = crc8_update(crc, cfg_serial[7:0]);
               r.read_data  = {cfg_serial, crc};
               r.data_bytes = SERIAL_LENGTH;
            end
         end
         FUNC_RD_ADC: begin
            if (cmd.read_length != ADC_LENGTH) begin
               r.status = ST_PROTO_ERR;
            end else if (dev_mode == MODE_CONVERTING) begin
               r.data_bytes = ADC_LENGTH;
            end else if (dev_mode == MODE_CONVERTED) begin
               crc = crc8_update(8'h00, adc_latch[15:8]);
               crc = crc8_update(crc, adc_latch[7:0]);
               r.read_data  = {8'h00, adc_latch, crc};
               r.data_bytes = ADC_LENGTH;
               enter_mode(MODE_IDLE);
            end else begin
               r.status = ST_NOT_READY;
            end
         end
         FUNC_TICK: begin
            if (ms_count != MS_SATURATE) ms_count = ms_count + 8'd1;
            if (dev_mode == MODE_RESET && ms_count > cfg_reset_wait) begin
               enter_mode(MODE_IDLE);
            end else if (dev_mode == MODE_CONVERTING && ms_count > cfg_conv_wait) begin
               adc_latch = cmd.sample_code;
               enter_mode(MODE_CONVERTED);
            end
         end
         default: begin
            r.status = ST_PROTO_ERR;
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] register_mirror(logic [1:0] idx);
      case (idx)
         REG_SERIAL:     return {8'h00, cfg_serial};
         REG_RESET_WAIT: return {24'h0, cfg_reset_wait};
         default:        return {24'h0, cfg_conv_wait};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type make_cmd(logic [2:0] func, logic [15:0] sample,
                                        logic [2:0] len);
      req_type c;
      c.func        = func;
      c.sample_code = sample;
      c.read_length = len;
      return c;
   endfunction

   // Any command at all: undefined codes and wrong lengths included, though
   // reads usually ask for the length that the device expects.
   function automatic req_type random_command();
      req_type c;
      c.func        = 3'($urandom_range(FUNC_MAX));
      c.sample_code = 16'($urandom);
      c.read_length = 3'($urandom);
      if ($urandom_range(1) == 0) begin
         if (c.func == FUNC_RD_SER) c.read_length = SERIAL_LENGTH;
         if (c.func == FUNC_RD_ADC) c.read_length = ADC_LENGTH;
      end
      return c;
   endfunction

   task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch on %s at %0t ns: expected 0x%0h, got 0x%0h",
                  what, $time, want, got);
      end
   endtask

   // Offers one command and returns at the edge on which its transfer
   // happens, having recorded the response that it must produce. Valid is
   // left high so that a following command can go out back to back.
   task automatic send_item(req_type cmd);
      int unsigned gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= req_type'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_replies.push_back(sensor_reply(cmd));
      items_sent++;
   endtask

   task automatic send_tick();
      if ($urandom_range(11) == 0) send_item(random_command());
      send_item(make_cmd(FUNC_TICK, 16'($urandom), 3'($urandom)));
   endtask

   // Drops valid and waits until every owed response has been transferred,
   // plus the pipeline depth, so that the block is idle afterwards.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase that completes on
   // the edge with pready high. Only the low bits of each register are kept.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_WIDTH'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         REG_SERIAL:     cfg_serial     = value[23:0];
         REG_RESET_WAIT: cfg_reset_wait = value[7:0];
         default:        cfg_conv_wait  = value[7:0];
      endcase
      cfg_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(logic [1:0] idx);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_WIDTH'({idx, 2'b00});
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== register_mirror(idx)) begin
         log_mismatch("register readback", register_mirror(idx), prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // A complete measurement: reset, optional serial read, the reset wait,
   // a conversion with reads along the way, then the result read. Noise may
   // be mixed into the tick stretches, and now and then the sender pauses
   // until the block has answered everything before going on.
   task automatic run_measurement_cycle();
      send_item(make_cmd(FUNC_RESET, 16'($urandom), 3'($urandom)));
      if ($urandom_range(1) == 0) begin
         send_item(make_cmd(FUNC_RD_SER, 16'($urandom), SERIAL_LENGTH));
      end
      repeat (int'(cfg_reset_wait) + 1 + $urandom_range(1)) send_tick();
      send_item(make_cmd(FUNC_CONVERT, 16'($urandom), 3'($urandom)));
      if ($urandom_range(1) == 0) begin
         send_item(make_cmd(FUNC_RD_ADC, 16'($urandom), ADC_LENGTH));
      end
      if ($urandom_range(7) == 0) wait_drained();
      repeat (int'(cfg_conv_wait) + 1 + $urandom_range(1)) send_tick();
      if ($urandom_range(3) == 0) begin
         send_item(make_cmd(FUNC_CONVERT, 16'($urandom), 3'($urandom)));
      end
      send_item(make_cmd(FUNC_RD_ADC, 16'($urandom), ADC_LENGTH));
      if ($urandom_range(9) < 3) begin
         send_item(make_cmd(FUNC_RD_ADC, 16'($urandom), ADC_LENGTH));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Walks the commands through every mode with the reset defaults
   // (reset wait 2 ms, convert wait 5 ms).
   task automatic test_directed_commands();
      // An untouched device refuses everything but reset and ticks.
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'hffff, ADC_LENGTH));
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, SERIAL_LENGTH));
      for (int f = FUNC_TICK + 1; f <= FUNC_MAX; f++) begin
         send_item(make_cmd(3'(f), 16'hffff, 3'd7));
      end
      send_item(make_cmd(FUNC_TICK, 16'h5a5a, 3'd0));
      send_item(make_cmd(FUNC_RESET, 16'h0000, 3'd0));
      // The serial number is readable in the reset mode, and only in full.
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, SERIAL_LENGTH));
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, 3'd7));
      repeat (3) send_item(make_cmd(FUNC_TICK, 16'h0000, 3'd0));
      // Now idle: the serial read is a protocol error, the ADC not ready.
      send_item(make_cmd(FUNC_RD_SER, 16'hffff, SERIAL_LENGTH));
      send_item(make_cmd(FUNC_RD_ADC, 16'hffff, ADC_LENGTH));
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, 3'd0));
      // A second convert restarts the conversion timer.
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      repeat (6) send_item(make_cmd(FUNC_TICK, 16'hffff, 3'd7));
      // Converted: a convert is refused, the code read once, then not ready.
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
   endtask

   // Reads back the defaults, writes every register with all ones in the
   // serial number and zero waits (junk in the unused upper bits), reads
   // them back and runs a short measurement with those values.
   task automatic test_register_access();
      wait_drained();
      for (int i = REG_SERIAL; i <= REG_CONV_WAIT; i++) csr_read_check(2'(i));
      csr_write(REG_SERIAL, 32'hffff_ffff);
      csr_write(REG_RESET_WAIT, 32'hffff_ff00);
      csr_write(REG_CONV_WAIT, 32'h8000_0000);
      for (int i = REG_SERIAL; i <= REG_CONV_WAIT; i++) csr_read_check(2'(i));
      send_item(make_cmd(FUNC_RESET, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, SERIAL_LENGTH));
      send_item(make_cmd(FUNC_TICK, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_TICK, 16'hffff, 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
   endtask

   // Random measurements and noise under a fresh random register setting.
   task automatic test_random_sequences(int count);
      int first;
      logic [31:0] value;
      wait_drained();
      csr_write(REG_SERIAL, $urandom);
      value = $urandom;
      value[7:0] = 8'($urandom_range(4));
      csr_write(REG_RESET_WAIT, value);
      value = $urandom;
      value[7:0] = 8'($urandom_range(6));
      csr_write(REG_CONV_WAIT, value);
      first = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 4)) send_item(random_command());
         end else begin
            run_measurement_cycle();
         end
      end
   endtask

   // The receiver holds off for a long stretch while commands keep coming,
   // so the block fills and has to stall its request side.
   task automatic test_backpressure();
      int first;
      wait_drained();
      hold_ask = 1'b1;
      first = items_sent;
      while (items_sent - first < 30) run_measurement_cycle();
   endtask

   // Waits of 255 never expire because the timer saturates there; a wait
   // of zero expires on the first tick.
   task automatic test_wait_extremes();
      wait_drained();
      csr_write(REG_RESET_WAIT, 32'h0000_00ff);
      csr_write(REG_CONV_WAIT, 32'h0000_00ff);
      send_item(make_cmd(FUNC_RESET, 16'h0000, 3'd0));
      repeat (258) send_item(make_cmd(FUNC_TICK, 16'($urandom), 3'd0));
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, SERIAL_LENGTH));
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      repeat (258) send_item(make_cmd(FUNC_TICK, 16'($urandom), 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
      wait_drained();
      csr_write(REG_SERIAL, 32'h0000_0000);
      csr_write(REG_RESET_WAIT, 32'h0000_0000);
      csr_write(REG_CONV_WAIT, 32'h0000_0000);
      send_item(make_cmd(FUNC_RESET, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_RD_SER, 16'h0000, SERIAL_LENGTH));
      send_item(make_cmd(FUNC_TICK, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_CONVERT, 16'h0000, 3'd0));
      send_item(make_cmd(FUNC_TICK, 16'h8001, 3'd0));
      send_item(make_cmd(FUNC_RD_ADC, 16'h0000, ADC_LENGTH));
   endtask

   // ------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------------

   // The receiver stalls at random, or solidly while the LONG_HOLD countdown runs once a
   // test asks for it. The stall only ever changes at the falling edge.
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_ask  = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Each response transfer is compared with the oldest owed response.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            log_mismatch("response with nothing outstanding", 32'h0, rsp_data.read_data);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_data.status !== want.status) begin
               log_mismatch("status", want.status, rsp_data.status);
            end
            if (rsp_data.read_data !== want.read_data) begin
               log_mismatch("read_data", want.read_data, rsp_data.read_data);
            end
            if (rsp_data.data_bytes !== want.data_bytes) begin
               log_mismatch("data_bytes", want.data_bytes, rsp_data.data_bytes);
            end
         end
      end
   end

   // Gives up when neither channel has moved a transfer for too long, and
   // counts the cycles in which the block pushed back on its input.
   always @(posedge clock) begin
      if (req_valid === 1'b1 && req_stall === 1'b1) input_stalls++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Sender idles often, receiver idles most of the time.
      send_idle_pct = 36;
      rcv_idle_pct  = 81;
      test_directed_commands();
      test_register_access();
      test_random_sequences(100);

      // The other way round.
      send_idle_pct = 81;
      rcv_idle_pct  = 36;
      test_random_sequences(100);

      // Neither side idles, apart from the long hold.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_backpressure();
      test_wait_extremes();
      test_random_sequences(100);

      wait_drained();
      if (awaited_replies.size() != 0) begin
         error_count += awaited_replies.size();
         $display("%0d responses never arrived", awaited_replies.size());
      end
      $display("Run covered %0d commands and %0d responses over %0d register writes,",
               items_sent, replies_seen, cfg_writes);
      $display("with random idling on both sides and %0d cycles of input back-pressure.",
               input_stalls);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
src/i2cts_pkg.sv
src/i2cts_csr.sv
src/i2cts_engine.sv
src/i2c_temp_sensor_command_model_core.sv
verif/tb_i2c_temp_sensor_command_model_core.sv
